// ----- rtl/core/serial_servo_command_display_macros.svh -----
// Assertion macros for the serial servo command and display block.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef SERIAL_SERVO_COMMAND_DISPLAY_MACROS_SVH
`define SERIAL_SERVO_COMMAND_DISPLAY_MACROS_SVH

// Implication within the same cycle, checked outside reset.
`define SSCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define SSCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sscd_pkg.sv -----
// Package for the serial servo command and display block: codes, constants
// and the small decode functions. Depends on nothing.
`default_nettype none

package sscd_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_TICK   = 2'd2
  } opcode_t;

  // Result kinds on the output channel
  typedef enum logic {
    KIND_LINE = 1'b0,
    KIND_SCAN = 1'b1
  } result_kind_t;

  typedef logic [3:0] digit_code_t;

  localparam logic [7:0]  LINE_END     = 8'h0A;
  localparam logic [7:0]  ASCII_ZERO   = 8'd48;
  localparam logic [7:0]  ASCII_NINE   = 8'd57;
  localparam logic [7:0]  ANGLE_MAX    = 8'd180;
  localparam logic [8:0]  SERVO_BASE   = 9'd300;
  localparam logic [11:0] SERVO_ROUND  = 12'd14;     // ceil for divide by 15
  localparam logic [10:0] DIM_OFF      = 11'd1960;
  localparam logic [31:0] BRIGHT_BASE  = 32'd1809986355; // 27618.2 in Q16
  localparam logic [31:0] BRIGHT_SLOPE = 32'd583866;     // 8.90909 in Q16
  localparam digit_code_t BLANK_CODE   = 4'd10;
  localparam logic [2:0]  LINE_FULL    = 3'd4;
  localparam logic [2:0]  LINE_LAST    = 3'd3;
  localparam logic [1:0]  LAST_DIGIT   = 2'd2;

  // ASCII decimal digit test
  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[ASCII_ZERO:ASCII_NINE]};
  endfunction

  // Seven-segment pattern, segments a..g on bits 0..6; blank and unused codes dark
  function automatic logic [6:0] seg_of(input digit_code_t code);
    logic [6:0] seg;
    case (code)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/serial_servo_command_display.sv -----
// Serial servo command and three-digit display block, top level.
// Depends on sscd_pkg and serial_servo_command_display_macros.svh.
//
// Usage:
//   Input channel (in_*): one item per transfer, tagged by in_opcode:
//   a serial byte, a 12-bit light sample or a display scan tick. Opcode 3
//   is dropped. Output channel (out_*): a line result on every 0x0A byte,
//   a scan result on every tick; bytes and samples give no result.
//   Both channels use valid/stall; a transfer happens on a clock edge with
//   valid high and stall low.
//   An item taken at an edge is registered in the input register, processed
//   from there in one pass and its result is captured in the result register.
//   Throughput: one item per cycle while out_stall is low, set by the input
//   register and the result register each moving once per cycle.
//   Stall: while out_stall holds a result, the input register keeps the next
//   item and in_stall rises only once that register is also occupied.
//   Reset (rst_n low, synchronous): both channels empty, line cleared,
//   value 0, brightness 0, display shows blank, blank, 0, scan at digit 0.
`default_nettype none

module serial_servo_command_display
  import sscd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [11:0] in_light_sample,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [8:0]       out_servo_compare,
  output logic [1:0]       out_reply_code,
  output logic [6:0]       out_segment_bits,
  output logic [1:0]       out_active_digit,
  output logic [10:0]      out_active_compare
);

  `include "serial_servo_command_display_macros.svh"

  // Input register
  logic        in_valid_r;
  logic [1:0]  in_opcode_r;
  logic [7:0]  in_rx_byte_r;
  logic [11:0] in_light_sample_r;

  // Result register
  logic        out_valid_r;
  logic        out_result_kind_r;
  logic [8:0]  out_servo_compare_r;
  logic [1:0]  out_reply_code_r;
  logic [6:0]  out_segment_bits_r;
  logic [1:0]  out_active_digit_r;
  logic [10:0] out_active_compare_r;

  // Block state
  logic [2:0]   line_count_r,      line_count_nxt;
  logic         short_line_r,      short_line_nxt;
  logic [7:0]   line_head_r [3];
  logic [7:0]   line_head_nxt [3];
  digit_code_t  shown_digits_r [3];
  digit_code_t  shown_digits_nxt [3];
  logic [7:0]   angle_value_r,     angle_value_nxt;
  logic [10:0]  brightness_r,      brightness_nxt;
  logic [1:0]   scan_pos_r,        scan_pos_nxt;

  // Handshake
  logic out_ready;
  logic in_accept;
  logic fire;

  assign out_ready = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && out_ready;
  assign in_stall  = in_valid_r && !out_ready;
  assign in_accept = in_valid && !in_stall;

  // Input register: holds one item until the result side can take it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_opcode_r       <= in_opcode;
      in_rx_byte_r      <= in_rx_byte;
      in_light_sample_r <= in_light_sample;
    end
  end

  // Line decode: digit count and digit values from the head bytes
  logic [1:0]  ndig;
  digit_code_t d0, d1, d2;
  logic [9:0]  line_value;

  always_comb begin
    ndig = 2'd0;
    if (short_line_r && is_digit(line_head_r[0])) begin
      ndig = 2'd1;
      if (is_digit(line_head_r[1])) begin
        ndig = 2'd2;
        if (is_digit(line_head_r[2])) begin
          ndig = 2'd3;
        end
      end
    end
  end

  always_comb begin
    case (ndig)
      2'd3: begin
        d0 = line_head_r[0][3:0];
        d1 = line_head_r[1][3:0];
        d2 = line_head_r[2][3:0];
      end
      2'd2: begin
        d0 = 4'd0;
        d1 = line_head_r[0][3:0];
        d2 = line_head_r[1][3:0];
      end
      2'd1: begin
        d0 = 4'd0;
        d1 = 4'd0;
        d2 = line_head_r[0][3:0];
      end
      default: begin
        d0 = 4'd0;
        d1 = 4'd0;
        d2 = 4'd0;
      end
    endcase
  end

  // d0*100 + d1*10 + d2 by shifts and adds
  assign line_value = ({6'd0, d0} << 6) + ({6'd0, d0} << 5) + ({6'd0, d0} << 2)
                    + ({6'd0, d1} << 3) + ({6'd0, d1} << 1) + {6'd0, d2};

  // Clamp to the maximum angle and blank leading zeros
  logic         value_over;
  logic [7:0]   new_angle;
  digit_code_t  c0, c1, c2;

  assign value_over = line_value > {2'd0, ANGLE_MAX};
  assign new_angle  = value_over ? ANGLE_MAX : line_value[7:0];

  always_comb begin
    if (value_over) begin
      c0 = 4'd1;
      c1 = 4'd8;
      c2 = 4'd0;
    end else begin
      c0 = d0;
      c1 = d1;
      c2 = d2;
    end
    if (c0 == 4'd0) begin
      c0 = BLANK_CODE;
      if (c1 == 4'd0) begin
        c1 = BLANK_CODE;
      end
    end
  end

  // Servo compare: 300 - ceil(19*v/15); the divide is x*4370 >> 16, exact here
  logic [7:0]  servo_angle;
  logic [11:0] servo_num;
  logic [24:0] servo_prod;
  logic [8:0]  servo_cmp;

  assign servo_angle = (ndig != 2'd0) ? new_angle : angle_value_r;
  assign servo_num   = ({4'd0, servo_angle} << 4) + ({4'd0, servo_angle} << 1)
                     + {4'd0, servo_angle} + SERVO_ROUND;
  assign servo_prod  = ({13'd0, servo_num} << 12) + ({13'd0, servo_num} << 8)
                     + ({13'd0, servo_num} << 4) + ({13'd0, servo_num} << 1);
  assign servo_cmp   = SERVO_BASE - servo_prod[24:16];

  // Brightness from the light sample in Q16, truncated and clamped
  logic [31:0] bright_prod;
  logic [31:0] bright_diff;
  logic [10:0] bright_val;

  assign bright_prod = BRIGHT_SLOPE * {20'd0, in_light_sample_r};
  assign bright_diff = BRIGHT_BASE - bright_prod;

  always_comb begin
    if (bright_prod > BRIGHT_BASE) begin
      bright_val = 11'd0;
    end else if (bright_diff[31:16] > {5'd0, DIM_OFF}) begin
      bright_val = DIM_OFF;
    end else begin
      bright_val = bright_diff[26:16];
    end
  end

  // Scan position in use this tick
  logic [1:0] scan_use;
  assign scan_use = (scan_pos_r > LAST_DIGIT) ? 2'd0 : scan_pos_r;

  // Next state and result for the item in the input register
  logic        res_valid;
  logic        res_kind;
  logic [8:0]  res_servo;
  logic [1:0]  res_reply;
  logic [6:0]  res_seg;
  logic [1:0]  res_digit;
  logic [10:0] res_compare;

  always_comb begin
    line_count_nxt   = line_count_r;
    short_line_nxt   = short_line_r;
    line_head_nxt    = line_head_r;
    shown_digits_nxt = shown_digits_r;
    angle_value_nxt  = angle_value_r;
    brightness_nxt   = brightness_r;
    scan_pos_nxt     = scan_pos_r;
    res_valid        = 1'b0;
    res_kind         = KIND_LINE;
    res_servo        = 9'd0;
    res_reply        = 2'd0;
    res_seg          = 7'd0;
    res_digit        = 2'd0;
    res_compare      = 11'd0;
    case (in_opcode_r)
      OP_BYTE: begin
        if (in_rx_byte_r == LINE_END) begin
          // Line end: take the value if there is one, then clear the line
          if (ndig != 2'd0) begin
            angle_value_nxt     = new_angle;
            shown_digits_nxt[0] = c0;
            shown_digits_nxt[1] = c1;
            shown_digits_nxt[2] = c2;
          end
          line_count_nxt = 3'd0;
          short_line_nxt = 1'b1;
          line_head_nxt  = '{3{8'd0}};
          res_valid      = 1'b1;
          res_kind       = KIND_LINE;
          res_servo      = servo_cmp;
          res_reply      = ndig;
        end else begin
          // Ordinary byte: keep the first three, judge the fourth
          if (line_count_r < LINE_LAST) begin
            line_head_nxt[line_count_r[1:0]] = in_rx_byte_r;
          end else if (line_count_r == LINE_LAST) begin
            if (in_rx_byte_r != 8'd0 && line_head_r[0] != 8'd0 &&
                line_head_r[1] != 8'd0 && line_head_r[2] != 8'd0) begin
              short_line_nxt = 1'b0;
            end
          end
          if (line_count_r < LINE_FULL) begin
            line_count_nxt = line_count_r + 3'd1;
          end
        end
      end
      OP_SAMPLE: begin
        brightness_nxt = bright_val;
      end
      OP_TICK: begin
        res_valid    = 1'b1;
        res_kind     = KIND_SCAN;
        res_seg      = seg_of(shown_digits_r[scan_use]);
        res_digit    = scan_use;
        res_compare  = brightness_r;
        scan_pos_nxt = (scan_use == LAST_DIGIT) ? 2'd0 : scan_use + 2'd1;
      end
      default: ;
    endcase
  end

  // State registers, advanced once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r    <= 3'd0;
      short_line_r    <= 1'b1;
      line_head_r     <= '{3{8'd0}};
      shown_digits_r  <= '{BLANK_CODE, BLANK_CODE, 4'd0};
      angle_value_r   <= 8'd0;
      brightness_r    <= 11'd0;
      scan_pos_r      <= 2'd0;
    end else if (fire) begin
      line_count_r    <= line_count_nxt;
      short_line_r    <= short_line_nxt;
      line_head_r     <= line_head_nxt;
      shown_digits_r  <= shown_digits_nxt;
      angle_value_r   <= angle_value_nxt;
      brightness_r    <= brightness_nxt;
      scan_pos_r      <= scan_pos_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && fire && res_valid) begin
      out_result_kind_r    <= res_kind;
      out_servo_compare_r  <= res_servo;
      out_reply_code_r     <= res_reply;
      out_segment_bits_r   <= res_seg;
      out_active_digit_r   <= res_digit;
      out_active_compare_r <= res_compare;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_result_kind_r;
  assign out_servo_compare  = out_servo_compare_r;
  assign out_reply_code     = out_reply_code_r;
  assign out_segment_bits   = out_segment_bits_r;
  assign out_active_digit   = out_active_digit_r;
  assign out_active_compare = out_active_compare_r;

  // Checks
  `SSCD_ASSERT_NEXT(a_item_held, in_valid_r && out_valid_r && out_stall, in_valid_r, "held item lost while result stalled")
  `SSCD_ASSERT_NOW(a_angle_range, 1'b1, angle_value_r <= ANGLE_MAX, "angle value above maximum")
  `SSCD_ASSERT_NOW(a_bright_range, 1'b1, brightness_r <= DIM_OFF, "brightness above dim limit")
  `SSCD_ASSERT_NOW(a_line_fields, out_valid_r && out_result_kind_r == KIND_LINE, out_segment_bits_r == 7'd0 && out_active_digit_r == 2'd0 && out_servo_compare_r >= 9'd72, "line result fields out of range")
  `SSCD_ASSERT_NOW(a_last_digit_shown, 1'b1, shown_digits_r[2] != BLANK_CODE, "units digit blanked")

endmodule

`default_nettype wire
